@@ src/apb_pkg.sv @@
`default_nettype none
package apb_pkg;

  // fixed field widths
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned DUR_W     = 24;
  localparam int unsigned FRAC_W    = 17;
  localparam int unsigned STATE_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // fraction results carry this many quotient bits below the binary point
  localparam int unsigned QUOT_BITS = 16;

  // full blend weight, also the progress ceiling
  localparam logic [FRAC_W-1:0] FULL_WEIGHT = 17'h10000;

  // reset values of the registers
  localparam logic [DUR_W-1:0]   DURATION_RESET   = 24'd1000;
  localparam logic [SPEED_W-1:0] SPEED_RESET      = 16'd256;
  localparam logic [DUR_W-1:0]   BLEND_TIME_RESET = 24'd500;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_TIME = 2'd2;

  // event codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_ATTACH = 3'd1;
  localparam logic [OP_W-1:0] OP_DETACH = 3'd2;
  localparam logic [OP_W-1:0] OP_PLAY   = 3'd3;
  localparam logic [OP_W-1:0] OP_PAUSE  = 3'd4;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd5;
  localparam logic [OP_W-1:0] OP_SEEK   = 3'd6;

  // playback states
  localparam logic [STATE_W-1:0] PS_NONE    = 2'd0;
  localparam logic [STATE_W-1:0] PS_PAUSED  = 2'd1;
  localparam logic [STATE_W-1:0] PS_PLAYING = 2'd2;

  // status fields of one finished result
  typedef struct packed {
    logic [STATE_W-1:0] play_state;
    logic [FRAC_W-1:0]  blend_weight;
    logic [FRAC_W-1:0]  progress;
    logic               accepted;
  } apb_status_t;

endpackage
`default_nettype wire

@@ src/apb_div.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
// the remainder must start below the divisor
module apb_div #(
  parameter int unsigned DIVIDEND_BITS = 33
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic [apb_pkg::DUR_W-1:0]            rem_init_i,
  input  wire logic [apb_pkg::DUR_W-1:0]            divisor_i,
  input  wire logic [DIVIDEND_BITS-1:0]             dividend_i,
  input  wire logic [$clog2(DIVIDEND_BITS+1)-1:0]   steps_i,
  output logic                                      busy_o,
  output logic [apb_pkg::DUR_W-1:0]                 rem_o,
  output logic [apb_pkg::QUOT_BITS-1:0]             quot_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_BITS + 1);
  localparam int unsigned RW    = apb_pkg::DUR_W;

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [RW-1:0]         rem_q, rem_d;
  logic [RW-1:0]         dsr_q, dsr_d;
  logic [DIVIDEND_BITS-1:0] dvd_q, dvd_d;
  logic [apb_pkg::QUOT_BITS-1:0] quot_q, quot_d;

  logic [RW:0] rem_sh;
  logic [RW:0] diff;
  logic        ge;

  // one trial subtraction
  assign rem_sh = {rem_q, dvd_q[DIVIDEND_BITS-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
      rem_d  = rem_init_i;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      dvd_d  = {dvd_q[DIVIDEND_BITS-2:0], 1'b0};
      quot_d = {quot_q[apb_pkg::QUOT_BITS-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

@@ src/apb_seq.sv @@
`default_nettype none
// event sequencer: playback state, one multiplier step and the shared divider
module apb_seq #(
  parameter int unsigned POSITION_BITS   = 24,
  parameter int unsigned SPEED_FRAC_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [apb_pkg::DUR_W-1:0]         dur_i,
  input  wire logic [apb_pkg::SPEED_W-1:0]       speed_i,
  input  wire logic [apb_pkg::DUR_W-1:0]         blend_time_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [apb_pkg::OP_W-1:0]          operation_i,
  input  wire logic [apb_pkg::ELAPSED_W-1:0]     elapsed_ms_i,
  input  wire logic                              loop_request_i,
  input  wire logic [apb_pkg::FRAC_W-1:0]        seek_fraction_i,
  output logic                                   res_valid_o,
  input  wire logic                              res_take_i,
  output logic [POSITION_BITS-1:0]               res_position_o,
  output apb_pkg::apb_status_t                   res_status_o
);

  localparam int unsigned PB     = POSITION_BITS;
  localparam int unsigned PROD_W = apb_pkg::DUR_W + apb_pkg::FRAC_W;
  localparam int unsigned ADV_W  = apb_pkg::ELAPSED_W + apb_pkg::SPEED_W - SPEED_FRAC_BITS;
  localparam int unsigned NPW    = ((PB > ADV_W) ? PB : ADV_W) + 1;
  localparam int unsigned CMP_W  = (NPW > apb_pkg::DUR_W) ? NPW : apb_pkg::DUR_W;
  localparam int unsigned CNT_W  = $clog2(NPW + 1);
  localparam int unsigned BCNT_W = apb_pkg::DUR_W + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_APPLY  = 4'd2;
  localparam logic [3:0] S_MODW   = 4'd3;
  localparam logic [3:0] S_BLEND  = 4'd4;
  localparam logic [3:0] S_BLENDW = 4'd5;
  localparam logic [3:0] S_PROG   = 4'd6;
  localparam logic [3:0] S_PROGW  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_q, state_d;

  // playback state
  logic [apb_pkg::STATE_W-1:0] mode_q, mode_d;
  logic [PB-1:0]               pos_q, pos_d;
  logic                        loop_q, loop_d;
  logic                        brun_q, brun_d;
  logic [apb_pkg::DUR_W-1:0]   bcnt_q, bcnt_d;
  logic [apb_pkg::FRAC_W-1:0]  blevel_q, blevel_d;

  // per-event working registers
  logic                        acc_q, acc_d;
  logic [apb_pkg::FRAC_W-1:0]  prog_q, prog_d;
  logic                        seek_q, seek_d;
  logic [apb_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [apb_pkg::DUR_W-1:0]   a_q, a_d;
  logic [apb_pkg::FRAC_W-1:0]  b_q, b_d;
  logic [PROD_W-1:0]           prod_q, prod_d;

  // divider requests
  logic                        div_start;
  logic [apb_pkg::DUR_W-1:0]   div_rem_init;
  logic [apb_pkg::DUR_W-1:0]   div_divisor;
  logic [NPW-1:0]              div_dividend;
  logic [CNT_W-1:0]            div_steps;
  logic                        div_busy;
  logic [apb_pkg::DUR_W-1:0]   div_rem;
  logic [apb_pkg::QUOT_BITS-1:0] div_quot;

  logic                        attached;
  logic [apb_pkg::FRAC_W-1:0]  frac_sat;
  logic [NPW-1:0]              np;
  logic                        np_past_end;
  logic [BCNT_W-1:0]           bsum;

  assign attached    = mode_q != apb_pkg::PS_NONE;
  assign frac_sat    = (seek_fraction_i > apb_pkg::FULL_WEIGHT) ? apb_pkg::FULL_WEIGHT
                                                                 : seek_fraction_i;
  // advanced position, one spare bit above the wider addend
  assign np          = NPW'(pos_q) + NPW'(prod_q >> SPEED_FRAC_BITS);
  assign np_past_end = CMP_W'(np) >= CMP_W'(dur_i);
  assign bsum        = BCNT_W'(bcnt_q) + BCNT_W'(elapsed_q);

  apb_div #(
    .DIVIDEND_BITS(NPW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .divisor_i  (div_divisor),
    .dividend_i (div_dividend),
    .steps_i    (div_steps),
    .busy_o     (div_busy),
    .rem_o      (div_rem),
    .quot_o     (div_quot)
  );

  // next-state logic
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    pos_d        = pos_q;
    loop_d       = loop_q;
    brun_d       = brun_q;
    bcnt_d       = bcnt_q;
    blevel_d     = blevel_q;
    acc_d        = acc_q;
    prog_d       = prog_q;
    seek_d       = seek_q;
    elapsed_d    = elapsed_q;
    a_d          = a_q;
    b_d          = b_q;
    prod_d       = prod_q;
    div_start    = 1'b0;
    div_rem_init = '0;
    div_divisor  = dur_i;
    div_dividend = '0;
    div_steps    = CNT_W'(apb_pkg::QUOT_BITS);
    res_valid_o  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          acc_d     = 1'b0;
          seek_d    = 1'b0;
          elapsed_d = elapsed_ms_i;
          state_d   = S_PROG;
          case (operation_i)
            apb_pkg::OP_TICK: begin
              if (mode_q == apb_pkg::PS_PLAYING) begin
                a_d     = apb_pkg::DUR_W'(speed_i);
                b_d     = apb_pkg::FRAC_W'(elapsed_ms_i);
                state_d = S_MUL;
              end
            end
            apb_pkg::OP_ATTACH: begin
              pos_d  = '0;
              brun_d = 1'b1;
              bcnt_d = '0;
              loop_d = 1'b0;
              if (mode_q == apb_pkg::PS_NONE) begin
                mode_d = apb_pkg::PS_PAUSED;
              end
            end
            apb_pkg::OP_DETACH: begin
              mode_d = apb_pkg::PS_NONE;
            end
            apb_pkg::OP_PLAY: begin
              acc_d = attached;
              if (attached) begin
                loop_d = loop_request_i;
                mode_d = apb_pkg::PS_PLAYING;
              end
            end
            apb_pkg::OP_PAUSE: begin
              acc_d = attached;
              if (attached) begin
                mode_d = apb_pkg::PS_PAUSED;
              end
            end
            apb_pkg::OP_REWIND: begin
              acc_d = attached;
              if (attached) begin
                pos_d = '0;
              end
            end
            apb_pkg::OP_SEEK: begin
              acc_d = attached;
              if (attached) begin
                a_d     = dur_i;
                b_d     = frac_sat;
                seek_d  = 1'b1;
                state_d = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // speed times elapsed, or duration times seek fraction
      S_MUL: begin
        prod_d  = PROD_W'(a_q) * PROD_W'(b_q);
        state_d = S_APPLY;
      end

      S_APPLY: begin
        if (seek_q) begin
          pos_d   = PB'(prod_q >> apb_pkg::QUOT_BITS);
          state_d = S_PROG;
        end else if (loop_q) begin
          if (np_past_end) begin
            div_start    = 1'b1;
            div_dividend = np;
            div_steps    = CNT_W'(NPW);
            state_d      = S_MODW;
          end else begin
            pos_d   = PB'(np);
            state_d = S_BLEND;
          end
        end else begin
          // play once: stop at the end
          if (np_past_end) begin
            pos_d  = PB'(dur_i);
            mode_d = apb_pkg::PS_PAUSED;
          end else begin
            pos_d = PB'(np);
          end
          state_d = S_BLEND;
        end
      end

      // wrap: remainder of the position by the duration
      S_MODW: begin
        if (!div_busy) begin
          pos_d   = PB'(div_rem);
          state_d = S_BLEND;
        end
      end

      // blend ramp on real elapsed time
      S_BLEND: begin
        state_d = S_PROG;
        if (brun_q) begin
          if (bsum >= BCNT_W'(blend_time_i)) begin
            bcnt_d   = blend_time_i;
            brun_d   = 1'b0;
            blevel_d = apb_pkg::FULL_WEIGHT;
          end else begin
            bcnt_d       = apb_pkg::DUR_W'(bsum);
            div_start    = 1'b1;
            div_rem_init = apb_pkg::DUR_W'(bsum);
            div_divisor  = blend_time_i;
            state_d      = S_BLENDW;
          end
        end
      end

      S_BLENDW: begin
        if (!div_busy) begin
          blevel_d = apb_pkg::FRAC_W'(div_quot);
          state_d  = S_PROG;
        end
      end

      // progress fraction, zero when detached, saturated at the end
      S_PROG: begin
        if (mode_q == apb_pkg::PS_NONE) begin
          prog_d  = '0;
          state_d = S_DONE;
        end else if (CMP_W'(pos_q) >= CMP_W'(dur_i)) begin
          prog_d  = apb_pkg::FULL_WEIGHT;
          state_d = S_DONE;
        end else begin
          div_start    = 1'b1;
          div_rem_init = apb_pkg::DUR_W'(pos_q);
          state_d      = S_PROGW;
        end
      end

      S_PROGW: begin
        if (!div_busy) begin
          prog_d  = apb_pkg::FRAC_W'(div_quot);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and playback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= apb_pkg::PS_NONE;
      pos_q    <= '0;
      loop_q   <= 1'b0;
      brun_q   <= 1'b1;
      bcnt_q   <= '0;
      blevel_q <= apb_pkg::FULL_WEIGHT;
      acc_q    <= 1'b0;
      prog_q   <= '0;
      seek_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      loop_q   <= loop_d;
      brun_q   <= brun_d;
      bcnt_q   <= bcnt_d;
      blevel_q <= blevel_d;
      acc_q    <= acc_d;
      prog_q   <= prog_d;
      seek_q   <= seek_d;
    end
  end

  // operands and product
  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    a_q       <= a_d;
    b_q       <= b_d;
    prod_q    <= prod_d;
  end

  assign in_stall_o                  = state_q != S_IDLE;
  assign res_position_o              = pos_q;
  assign res_status_o.play_state     = mode_q;
  assign res_status_o.blend_weight   = blevel_q;
  assign res_status_o.progress       = prog_q;
  assign res_status_o.accepted       = acc_q;

endmodule
`default_nettype wire

@@ src/animation_playback_clock.sv @@
`default_nettype none
// Animation playback clock. Each input transaction is one event (tick, attach, detach,
// play, pause, rewind, seek) and yields exactly one result transaction with the position,
// play state, blend weight, progress and accepted flag. The block takes one event at a
// time: an event that only changes state waits at most on the progress division; a tick
// while playing also runs the blend ramp division while the ramp runs, and a wrap division
// over the bits of the advanced position when the position wraps in loop mode, since the
// wrap remainder, the blend ramp fraction and the progress fraction all run one after
// another through a single shared divider that retires one bit per cycle. A new event is
// taken while the previous result still waits in the output register. Registers are to
// be written through the plain write port only while the block is idle; the block itself
// does not enforce this. A zero duration or blend time counts as one millisecond.
module animation_playback_clock #(
  parameter int unsigned POSITION_BITS   = 24,
  parameter int unsigned SPEED_FRAC_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [apb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [apb_pkg::DUR_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [apb_pkg::OP_W-1:0]          operation_i,
  input  wire logic [apb_pkg::ELAPSED_W-1:0]     elapsed_ms_i,
  input  wire logic                              loop_request_i,
  input  wire logic [apb_pkg::FRAC_W-1:0]        seek_fraction_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [POSITION_BITS-1:0]               position_ms_o,
  output logic [apb_pkg::STATE_W-1:0]            play_state_o,
  output logic [apb_pkg::FRAC_W-1:0]             blend_weight_o,
  output logic [apb_pkg::FRAC_W-1:0]             progress_o,
  output logic                                   accepted_o
);

  logic [apb_pkg::DUR_W-1:0]   duration_q;
  logic [apb_pkg::SPEED_W-1:0] speed_q;
  logic [apb_pkg::DUR_W-1:0]   blend_time_q;
  logic [apb_pkg::DUR_W-1:0]   dur_eff;
  logic [apb_pkg::DUR_W-1:0]   bt_eff;

  logic                        res_valid;
  logic                        res_take;
  logic [POSITION_BITS-1:0]    res_position;
  apb_pkg::apb_status_t        res_status;

  logic                        out_valid_q;
  logic [POSITION_BITS-1:0]    out_pos_q;
  apb_pkg::apb_status_t        out_status_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q   <= apb_pkg::DURATION_RESET;
      speed_q      <= apb_pkg::SPEED_RESET;
      blend_time_q <= apb_pkg::BLEND_TIME_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        apb_pkg::REG_DURATION:   duration_q   <= cfg_wdata_i;
        apb_pkg::REG_SPEED:      speed_q      <= cfg_wdata_i[apb_pkg::SPEED_W-1:0];
        apb_pkg::REG_BLEND_TIME: blend_time_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // zero lengths count as one millisecond
  assign dur_eff = (duration_q == '0) ? apb_pkg::DUR_W'(1) : duration_q;
  assign bt_eff  = (blend_time_q == '0) ? apb_pkg::DUR_W'(1) : blend_time_q;

  apb_seq #(
    .POSITION_BITS   (POSITION_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .dur_i           (dur_eff),
    .speed_i         (speed_q),
    .blend_time_i    (bt_eff),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .loop_request_i  (loop_request_i),
    .seek_fraction_i (seek_fraction_i),
    .res_valid_o     (res_valid),
    .res_take_i      (res_take),
    .res_position_o  (res_position),
    .res_status_o    (res_status)
  );

  // output register, loaded when empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_pos_q    <= res_position;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_ms_o  = out_pos_q;
  assign play_state_o   = out_status_q.play_state;
  assign blend_weight_o = out_status_q.blend_weight;
  assign progress_o     = out_status_q.progress;
  assign accepted_o     = out_status_q.accepted;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

// unused operation code, the block must answer it without a state change
localparam logic [apb_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

// speed fraction bits and position width of the instance under test
localparam int SPEED_SHIFT = 8;
localparam int POS_W       = 24;

// one expected result transaction
typedef struct {
  logic [POS_W-1:0]             position;
  logic [apb_pkg::STATE_W-1:0]  play_state;
  logic [apb_pkg::FRAC_W-1:0]   blend_weight;
  logic [apb_pkg::FRAC_W-1:0]   progress;
  logic                         accepted;
} playback_result_t;

// playback clock predictor and the queue of results it still expects
class playback_scoreboard;
  logic [apb_pkg::DUR_W-1:0]    duration_reg;
  logic [apb_pkg::SPEED_W-1:0]  speed_reg;
  logic [apb_pkg::DUR_W-1:0]    blend_time_reg;

  logic [apb_pkg::STATE_W-1:0]  mode;
  logic [POS_W-1:0]             pos;
  logic                         looping;
  logic                         blend_running;
  logic [apb_pkg::DUR_W-1:0]    blend_count;
  logic [apb_pkg::FRAC_W-1:0]   blend_level;

  playback_result_t expected_q[$];
  int unsigned      checked;
  int unsigned      failures;

  function new();
    duration_reg   = apb_pkg::DURATION_RESET;
    speed_reg      = apb_pkg::SPEED_RESET;
    blend_time_reg = apb_pkg::BLEND_TIME_RESET;
    mode           = apb_pkg::PS_NONE;
    pos            = '0;
    looping        = 1'b0;
    blend_running  = 1'b1;
    blend_count    = '0;
    blend_level    = apb_pkg::FULL_WEIGHT;
    checked        = 0;
    failures       = 0;
  endfunction

  function void set_register(logic [apb_pkg::CFG_IDX_W-1:0] idx,
                             logic [apb_pkg::DUR_W-1:0] val);
    case (idx)
      apb_pkg::REG_DURATION:   duration_reg   = val;
      apb_pkg::REG_SPEED:      speed_reg      = val[apb_pkg::SPEED_W-1:0];
      apb_pkg::REG_BLEND_TIME: blend_time_reg = val;
      default: ;
    endcase
  endfunction

  // apply one accepted event and queue the result it must produce
  function void note_event(logic [apb_pkg::OP_W-1:0] op,
                           logic [apb_pkg::ELAPSED_W-1:0] elapsed,
                           logic loop_req,
                           logic [apb_pkg::FRAC_W-1:0] frac);
    playback_result_t  res;
    logic              attached;
    longint unsigned   dur, bt, e, np, cnt, f, prog;
    attached = (mode != apb_pkg::PS_NONE);
    dur = (duration_reg == 0) ? 64'd1 : 64'(duration_reg);
    res.accepted = 1'b0;
    case (op)
      apb_pkg::OP_TICK: begin
        if (mode == apb_pkg::PS_PLAYING) begin
          e  = 64'(elapsed);
          np = 64'(pos) + ((e * 64'(speed_reg)) >> SPEED_SHIFT);
          if (looping) begin
            np = np % dur;
          end else if (np >= dur) begin
            // play-once run reaches the end, also when the duration shrank
            np   = dur;
            mode = apb_pkg::PS_PAUSED;
          end
          pos = np[POS_W-1:0];
          // blend ramp counts real time, not scaled time
          if (blend_running) begin
            bt  = (blend_time_reg == 0) ? 64'd1 : 64'(blend_time_reg);
            cnt = 64'(blend_count) + e;
            if (cnt >= bt) begin
              blend_count   = bt[apb_pkg::DUR_W-1:0];
              blend_running = 1'b0;
              blend_level   = apb_pkg::FULL_WEIGHT;
            end else begin
              blend_count = cnt[apb_pkg::DUR_W-1:0];
              blend_level = apb_pkg::FRAC_W'((cnt * 64'(apb_pkg::FULL_WEIGHT)) / bt);
            end
          end
        end
      end
      apb_pkg::OP_ATTACH: begin
        // blend level is kept until the next tick
        pos           = '0;
        blend_running = 1'b1;
        blend_count   = '0;
        looping       = 1'b0;
        if (!attached) mode = apb_pkg::PS_PAUSED;
      end
      apb_pkg::OP_DETACH: begin
        mode = apb_pkg::PS_NONE;
      end
      apb_pkg::OP_PLAY: begin
        if (attached) begin
          looping = loop_req;
          mode    = apb_pkg::PS_PLAYING;
        end
        res.accepted = attached;
      end
      apb_pkg::OP_PAUSE: begin
        if (attached) mode = apb_pkg::PS_PAUSED;
        res.accepted = attached;
      end
      apb_pkg::OP_REWIND: begin
        if (attached) pos = '0;
        res.accepted = attached;
      end
      apb_pkg::OP_SEEK: begin
        if (attached) begin
          f   = (frac > apb_pkg::FULL_WEIGHT) ? 64'(apb_pkg::FULL_WEIGHT) : 64'(frac);
          np  = (dur * f) >> apb_pkg::QUOT_BITS;
          pos = np[POS_W-1:0];
        end
        res.accepted = attached;
      end
      default: ;
    endcase

    prog = 64'd0;
    if (mode != apb_pkg::PS_NONE) begin
      prog = (64'(pos) * 64'(apb_pkg::FULL_WEIGHT)) / dur;
      if (prog > 64'(apb_pkg::FULL_WEIGHT)) prog = 64'(apb_pkg::FULL_WEIGHT);
    end
    res.position     = pos;
    res.play_state   = mode;
    res.blend_weight = blend_level;
    res.progress     = prog[apb_pkg::FRAC_W-1:0];
    expected_q.push_back(res);
  endfunction

  function void compare_field(string field, logic [POS_W-1:0] expv,
                              logic [POS_W-1:0] act);
    if (act !== expv) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, expv, act);
      failures++;
    end
  endfunction

  // compare one result transaction with the oldest expectation
  function void check_result(logic [POS_W-1:0] position,
                             logic [apb_pkg::STATE_W-1:0] play_state,
                             logic [apb_pkg::FRAC_W-1:0] blend_weight,
                             logic [apb_pkg::FRAC_W-1:0] progress,
                             logic accepted);
    playback_result_t exp_res;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result transaction, position %0d state %0d",
               $time, position, play_state);
      failures++;
      return;
    end
    exp_res = expected_q.pop_front();
    checked++;
    compare_field("position_ms", exp_res.position, position);
    compare_field("play_state", POS_W'(exp_res.play_state), POS_W'(play_state));
    compare_field("blend_weight", POS_W'(exp_res.blend_weight), POS_W'(blend_weight));
    compare_field("progress", POS_W'(exp_res.progress), POS_W'(progress));
    compare_field("accepted", POS_W'(exp_res.accepted), POS_W'(accepted));
  endfunction
endclass

module testbench;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int PHASES          = 10;
  localparam int EVENTS_PER_PHASE = 125;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [apb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [apb_pkg::DUR_W-1:0]      cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [apb_pkg::OP_W-1:0]       operation = '0;
  logic [apb_pkg::ELAPSED_W-1:0]  elapsed_ms = '0;
  logic                           loop_request = 1'b0;
  logic [apb_pkg::FRAC_W-1:0]     seek_fraction = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b1;
  logic [POS_W-1:0]               position_ms;
  logic [apb_pkg::STATE_W-1:0]    play_state;
  logic [apb_pkg::FRAC_W-1:0]     blend_weight;
  logic [apb_pkg::FRAC_W-1:0]     progress;
  logic                           accepted;

  playback_scoreboard sb;
  logic        tx_noise = 1'b1;
  logic        rx_noise = 1'b1;
  logic        hold_request = 1'b0;
  int unsigned hold_count = 0;
  logic        hold_done = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned events_sent = 0;
  int unsigned settings_used = 0;

  animation_playback_clock DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .elapsed_ms_i   (elapsed_ms),
    .loop_request_i (loop_request),
    .seek_fraction_i(seek_fraction),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .position_ms_o  (position_ms),
    .play_state_o   (play_state),
    .blend_weight_o (blend_weight),
    .progress_o     (progress),
    .accepted_o     (accepted)
  );

  always #2 clk_i = ~clk_i;

  // result side: check each transaction, then pick the next stall value
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        sb.check_result(position_ms, play_state, blend_weight, progress, accepted);
      end
      if (hold_request && !hold_done) begin
        // long hold-off so the block fills up and stalls its input
        out_stall <= 1'b1;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rx_noise && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles",
               $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // offer one event and wait for its transaction; valid stays high afterwards
  task automatic send_event(input logic [apb_pkg::OP_W-1:0] op,
                            input logic [apb_pkg::ELAPSED_W-1:0] el,
                            input logic lp,
                            input logic [apb_pkg::FRAC_W-1:0] fr);
    in_valid      <= 1'b1;
    operation     <= op;
    elapsed_ms    <= el;
    loop_request  <= lp;
    seek_fraction <= fr;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.note_event(op, el, lp, fr);
    events_sent++;
  endtask

  // random burst of idle cycles on the event side
  task automatic sender_gap();
    if (tx_noise && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // drain every expected result, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // write all three registers on consecutive edges
  task automatic program_registers(input logic [apb_pkg::DUR_W-1:0] dur,
                                   input logic [apb_pkg::SPEED_W-1:0] spd,
                                   input logic [apb_pkg::DUR_W-1:0] bt);
    logic [apb_pkg::DUR_W-1:0]     vals[3];
    logic [apb_pkg::CFG_IDX_W-1:0] idxs[3];
    vals[0] = dur;
    vals[1] = {8'h00, spd};
    vals[2] = bt;
    idxs[0] = apb_pkg::REG_DURATION;
    idxs[1] = apb_pkg::REG_SPEED;
    idxs[2] = apb_pkg::REG_BLEND_TIME;
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk_i);
      sb.set_register(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // random event, weighted towards an attached and playing clock
  task automatic send_random_event();
    logic [apb_pkg::OP_W-1:0]      op;
    logic [apb_pkg::ELAPSED_W-1:0] el;
    logic [apb_pkg::FRAC_W-1:0]    fr;
    int unsigned                   pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = apb_pkg::OP_TICK;
    else if (pick < 57) op = apb_pkg::OP_PLAY;
    else if (pick < 63) op = apb_pkg::OP_ATTACH;
    else if (pick < 67) op = apb_pkg::OP_DETACH;
    else if (pick < 74) op = apb_pkg::OP_PAUSE;
    else if (pick < 79) op = apb_pkg::OP_REWIND;
    else if (pick < 97) op = apb_pkg::OP_SEEK;
    else                op = OP_UNUSED;
    case ($urandom_range(0, 3))
      0:       el = apb_pkg::ELAPSED_W'($urandom_range(0, 16));
      1:       el = apb_pkg::ELAPSED_W'($urandom_range(0, 40));
      2:       el = apb_pkg::ELAPSED_W'($urandom_range(0, 1000));
      default: el = apb_pkg::ELAPSED_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       fr = apb_pkg::FRAC_W'($urandom);
      1:       fr = apb_pkg::FULL_WEIGHT;
      2:       fr = '0;
      default: fr = apb_pkg::FRAC_W'($urandom_range(0, 65536));
    endcase
    send_event(op, el, 1'($urandom_range(0, 1)), fr);
  endtask

  initial begin
    logic [apb_pkg::DUR_W-1:0]   dur, bt;
    logic [apb_pkg::SPEED_W-1:0] spd;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: detached events, play once to the end, seeks, looping wrap
    send_event(apb_pkg::OP_TICK, 16'd500, 1'b0, '0);
    send_event(apb_pkg::OP_PLAY, '0, 1'b1, '0);
    send_event(apb_pkg::OP_PAUSE, '0, 1'b0, '0);
    send_event(apb_pkg::OP_REWIND, '0, 1'b0, '0);
    send_event(apb_pkg::OP_SEEK, '0, 1'b0, apb_pkg::FULL_WEIGHT);
    send_event(OP_UNUSED, 16'hFFFF, 1'b1, 17'h1FFFF);
    send_event(apb_pkg::OP_ATTACH, '0, 1'b0, '0);
    send_event(apb_pkg::OP_PLAY, '0, 1'b0, '0);
    send_event(apb_pkg::OP_TICK, 16'd100, 1'b0, '0);
    send_event(apb_pkg::OP_TICK, 16'd0, 1'b0, '0);
    send_event(apb_pkg::OP_TICK, 16'hFFFF, 1'b0, '0);
    send_event(apb_pkg::OP_SEEK, '0, 1'b0, 17'h1FFFF);
    send_event(apb_pkg::OP_SEEK, '0, 1'b0, '0);
    send_event(apb_pkg::OP_SEEK, '0, 1'b0, 17'd32768);
    send_event(apb_pkg::OP_REWIND, '0, 1'b0, '0);
    send_event(apb_pkg::OP_PLAY, '0, 1'b1, '0);
    send_event(apb_pkg::OP_TICK, 16'hFFFF, 1'b0, '0);
    send_event(apb_pkg::OP_TICK, 16'd1234, 1'b0, '0);
    send_event(OP_UNUSED, '0, 1'b0, '0);
    send_event(apb_pkg::OP_ATTACH, '0, 1'b0, '0);
    send_event(apb_pkg::OP_TICK, 16'd250, 1'b0, '0);
    send_event(apb_pkg::OP_DETACH, '0, 1'b0, '0);
    send_event(apb_pkg::OP_DETACH, '0, 1'b0, '0);
    send_event(apb_pkg::OP_ATTACH, '0, 1'b0, '0);
    send_event(apb_pkg::OP_SEEK, '0, 1'b0, apb_pkg::FULL_WEIGHT);

    // shrink the duration under the position, then a play-once tick clamps
    wait_idle();
    program_registers(24'd300, 16'd256, 24'd500);
    send_event(apb_pkg::OP_PLAY, '0, 1'b0, '0);
    send_event(apb_pkg::OP_TICK, 16'd0, 1'b0, '0);

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin dur = 24'hFFFFFF; spd = 16'hFFFF; bt = 24'hFFFFFF; end
        1: begin dur = '0; spd = '0; bt = '0; end
        2: begin dur = 24'd1; spd = 16'd256; bt = 24'd1; end
        3: begin
          dur = apb_pkg::DUR_W'($urandom_range(100, 5000));
          spd = 16'd256;
          bt  = 24'd500;
        end
        4: begin
          dur = apb_pkg::DUR_W'($urandom);
          spd = apb_pkg::SPEED_W'($urandom);
          bt  = apb_pkg::DUR_W'($urandom);
        end
        5: begin
          dur = apb_pkg::DUR_W'($urandom_range(1, 100));
          spd = apb_pkg::SPEED_W'($urandom_range(0, 2048));
          bt  = apb_pkg::DUR_W'($urandom_range(1, 200));
        end
        default: begin
          dur = apb_pkg::DUR_W'($urandom_range(1, 20000));
          spd = apb_pkg::SPEED_W'($urandom_range(0, 1024));
          bt  = apb_pkg::DUR_W'($urandom_range(1, 5000));
        end
      endcase
      program_registers(dur, spd, bt);
      // no idling in one middle stretch and in the closing phase
      tx_noise = (p != 5 && p != PHASES - 1);
      rx_noise <= (p != 5 && p != PHASES - 1);
      if (p == 3) hold_request <= 1'b1;
      for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
        sender_gap();
        send_random_event();
      end
    end

    // end of stimulus: drain and wait out the slowest event
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
      sb.failures++;
    end
    $display("covered %0d events over %0d register settings, %0d results compared",
             events_sent, settings_used + 1, sb.checked);
    $display("including detached events, clamped and looping playback and an output hold-off");
    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/apb_pkg.sv
src/apb_div.sv
src/apb_seq.sv
src/animation_playback_clock.sv
test/testbench.sv
